### hdl/fdmc_pkg.sv
package fdmc_pkg;

	localparam int FRAME_PIXELS = 65536;
	localparam int ADDR_W       = $clog2(FRAME_PIXELS);
	localparam int POS_W        = $clog2(FRAME_PIXELS + 1);

	localparam int TALLY_W = 17;
	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	localparam logic [7:0] THR_RESET = 8'd25;

	// gray weights, q14 fixed point
	localparam int SUM_W      = 22;
	localparam int GRAY_SHIFT = 14;
	localparam logic [SUM_W-1:0] GRAY_WB    = SUM_W'(1868);
	localparam logic [SUM_W-1:0] GRAY_WG    = SUM_W'(9617);
	localparam logic [SUM_W-1:0] GRAY_WR    = SUM_W'(4899);
	localparam logic [SUM_W-1:0] GRAY_ROUND = SUM_W'(8192);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// per-word control carried down the pipeline
	typedef struct packed {
		logic valid;
		logic cmp;
		logic last;
		logic emit;
		logic ovf;
	} ctl_t;

	typedef struct packed {
		logic               oversize;
		logic [TALLY_W-1:0] changed_count;
	} result_t;

endpackage

### hdl/frame_difference_motion_counter_core.sv
// data path: stage 1 register, gray-diff registers s2, s3, s4, then the output register
// throughput: one pixel per cycle; the pipeline stalls only while the output
// register and its skid word are both full
// reset: async active low; clears position and tally, sets first-frame flag, threshold=25;
// pixel store is not cleared, so no startup pass is needed
module frame_difference_motion_counter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // pixel_blue[7:0], pixel_green[15:8], pixel_red[23:16]
	input  logic        s_axis_tlast,  // frame_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // changed_count[16:0], zero[23:17]
	output logic        m_axis_tuser   // oversize
);

	logic [7:0] thr_q;
	logic [fdmc_pkg::POS_W-1:0] pos_q;
	logic first_q, ovf_seen_q;
	logic adv, accept, in_range, ovf_item;

	fdmc_pkg::ctl_t   ctl_s0, ctl_s1, ctl_g;
	fdmc_pkg::pixel_t pix_in, pix_s1, old_pix;
	logic [fdmc_pkg::ADDR_W-1:0] addr_s1;
	logic wr_s1, changed, stall;
	fdmc_pkg::result_t res;

	assign adv           = !stall;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign pix_in        = fdmc_pkg::pixel_t'(s_axis_tdata);

	assign in_range = pos_q < fdmc_pkg::POS_W'(fdmc_pkg::FRAME_PIXELS);
	assign ovf_item = ovf_seen_q || !in_range;

	assign ctl_s0.valid = accept;
	assign ctl_s0.cmp   = in_range && !first_q;
	assign ctl_s0.last  = s_axis_tlast;
	assign ctl_s0.emit  = s_axis_tlast && !first_q;
	assign ctl_s0.ovf   = ovf_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= fdmc_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// frame position bookkeeping at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			first_q    <= 1'b1;
			ovf_seen_q <= 1'b0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				pos_q      <= '0;
				first_q    <= 1'b0;
				ovf_seen_q <= 1'b0;
			end else begin
				if (in_range) begin
					pos_q <= pos_q + 1'b1;
				end
				ovf_seen_q <= ovf_item;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1  <= pix_in;
			addr_s1 <= pos_q[fdmc_pkg::ADDR_W-1:0];
			wr_s1   <= in_range;
		end
	end

	fdmc_pixel_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.rd_addr (pos_q[fdmc_pkg::ADDR_W-1:0]),
		.wr_en   (ctl_s1.valid && wr_s1),
		.wr_addr (addr_s1),
		.wr_data (pix_s1),
		.rd_data (old_pix)
	);

	fdmc_gray_diff u_gray (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ctl_in  (ctl_s1),
		.cur     (pix_s1),
		.old     (old_pix),
		.thr     (thr_q),
		.ctl_out (ctl_g),
		.changed (changed)
	);

	fdmc_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_g),
		.changed   (changed),
		.stall     (stall),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {7'd0, res.changed_count};
	assign m_axis_tuser = res.oversize;

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= fdmc_pkg::POS_W'(fdmc_pkg::FRAME_PIXELS))
		else $error("pixel position beyond store capacity");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tlast) |=> (pos_q == '0 && !first_q && !ovf_seen_q))
		else $error("frame state not restarted after last word");

endmodule

### hdl/fdmc_pixel_store.sv
module fdmc_pixel_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [fdmc_pkg::ADDR_W-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [fdmc_pkg::ADDR_W-1:0] wr_addr,
	input  fdmc_pkg::pixel_t         wr_data,
	output fdmc_pkg::pixel_t         rd_data
);

	fdmc_pkg::pixel_t mem [fdmc_pkg::FRAME_PIXELS];
	fdmc_pkg::pixel_t rdata_q;
	fdmc_pkg::pixel_t fwd_data_q;
	logic             fwd_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_en) begin
				mem[wr_addr] <= wr_data;
			end
			rdata_q    <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// read and write of the same entry on one edge: ram returns stale data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rdata_q;

endmodule

### hdl/fdmc_gray_diff.sv
module fdmc_gray_diff (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  fdmc_pkg::ctl_t   ctl_in,
	input  fdmc_pkg::pixel_t cur,
	input  fdmc_pkg::pixel_t old,
	input  logic [7:0]       thr,
	output fdmc_pkg::ctl_t   ctl_out,
	output logic             changed
);

	fdmc_pkg::ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic [7:0] db_s2, dg_s2, dr_s2;
	logic [fdmc_pkg::SUM_W-1:0] pb_s3, pg_s3, pr_s3;
	logic [fdmc_pkg::SUM_W-1:0] sum;
	logic [7:0] gray;
	logic changed_s4;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	assign sum  = pb_s3 + pg_s3 + pr_s3 + fdmc_pkg::GRAY_ROUND;
	assign gray = sum[fdmc_pkg::GRAY_SHIFT +: 8];

	always_ff @(posedge clk) begin
		if (en) begin
			db_s2      <= abs_diff(cur.blue, old.blue);
			dg_s2      <= abs_diff(cur.green, old.green);
			dr_s2      <= abs_diff(cur.red, old.red);
			pb_s3      <= fdmc_pkg::SUM_W'(db_s2) * fdmc_pkg::GRAY_WB;
			pg_s3      <= fdmc_pkg::SUM_W'(dg_s2) * fdmc_pkg::GRAY_WG;
			pr_s3      <= fdmc_pkg::SUM_W'(dr_s2) * fdmc_pkg::GRAY_WR;
			changed_s4 <= gray > thr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	assign ctl_out = ctl_s4;
	assign changed = changed_s4;

endmodule

### hdl/fdmc_result.sv
module fdmc_result (
	input  logic             clk,
	input  logic             arst_n,
	input  fdmc_pkg::ctl_t   ctl_in,
	input  logic             changed,
	output logic             stall,
	output logic             out_valid,
	input  logic             out_ready,
	output fdmc_pkg::result_t out_res
);

	logic [fdmc_pkg::TALLY_W-1:0] tally_q;
	logic [fdmc_pkg::TALLY_W-1:0] tally_next;
	fdmc_pkg::result_t out_q, skid_q, res;
	logic out_valid_q, skid_valid_q;
	logic take, new_res;

	assign stall   = skid_valid_q;
	assign take    = out_valid_q && out_ready;
	assign new_res = ctl_in.valid && ctl_in.emit;

	assign tally_next = tally_q + fdmc_pkg::TALLY_W'(ctl_in.cmp && changed &&
		(tally_q != fdmc_pkg::TALLY_MAX));
	assign res.changed_count = tally_next;
	assign res.oversize      = ctl_in.ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q      <= '0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (skid_valid_q) begin
			// pipeline frozen until the skid word moves up
			if (take) begin
				out_q        <= skid_q;
				skid_valid_q <= 1'b0;
			end
		end else begin
			if (ctl_in.valid) begin
				tally_q <= ctl_in.last ? '0 : tally_next;
			end
			if (!out_valid_q || take) begin
				out_valid_q <= new_res;
				if (new_res) begin
					out_q <= res;
				end
			end else if (new_res) begin
				skid_valid_q <= 1'b1;
				skid_q       <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with empty output register");

	a_tally_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_in.valid && ctl_in.last && !skid_valid_q) |=> (tally_q == '0))
		else $error("tally not cleared after frame end");

endmodule

### tb/frame_difference_motion_counter_core_tb.sv
module frame_difference_motion_counter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// longest frame of the run; the first frame has this length
	localparam int FILL_LEN    = 160;
	localparam int LONG_HOLD   = 150;
	localparam int SETTLE      = 10;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 150;
	localparam longint LIMIT_NS = 20_000_000;

	typedef struct packed {
		fdmc_pkg::pixel_t  px;
		logic              last;
		logic              typed;
		fdmc_pkg::result_t res;
	} pixel_row_t;

	localparam int DIR_ROWS = 17;

	// frame a is compared against the random fill, the rest follow from earlier rows
	localparam pixel_row_t DIR_TABLE [DIR_ROWS] = '{
		'{'{8'd0,   8'd0,   8'd0  }, 1'b0, 1'b0, '0},
		'{'{8'd255, 8'd255, 8'd255}, 1'b0, 1'b0, '0},
		'{'{8'd0,   8'd0,   8'd0  }, 1'b0, 1'b0, '0},
		'{'{8'd0,   8'd0,   8'd255}, 1'b1, 1'b0, '0},
		'{'{8'd0,   8'd0,   8'd0  }, 1'b0, 1'b0, '0},
		'{'{8'd255, 8'd255, 8'd255}, 1'b0, 1'b0, '0},
		'{'{8'd0,   8'd0,   8'd0  }, 1'b0, 1'b0, '0},
		'{'{8'd0,   8'd0,   8'd255}, 1'b1, 1'b1, '{1'b0, 17'd0}},
		'{'{8'd255, 8'd255, 8'd255}, 1'b0, 1'b0, '0},
		'{'{8'd0,   8'd0,   8'd0  }, 1'b0, 1'b0, '0},
		'{'{8'd255, 8'd255, 8'd255}, 1'b0, 1'b0, '0},
		'{'{8'd255, 8'd255, 8'd0  }, 1'b1, 1'b1, '{1'b0, 17'd4}},
		'{'{8'd255, 8'd255, 8'd255}, 1'b1, 1'b1, '{1'b0, 17'd0}},
		// threshold edges: green-only diffs of 44 and 42, blue-only and red-only full swings
		'{'{8'd255, 8'd211, 8'd255}, 1'b0, 1'b0, '0},
		'{'{8'd0,   8'd42,  8'd0  }, 1'b0, 1'b0, '0},
		'{'{8'd255, 8'd255, 8'd0  }, 1'b0, 1'b0, '0},
		'{'{8'd0,   8'd255, 8'd0  }, 1'b1, 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;

	// predictor state
	fdmc_pkg::pixel_t stored_frame [fdmc_pkg::FRAME_PIXELS];
	bit          awaiting_first = 1'b1;
	int unsigned frame_pos      = 0;
	logic [fdmc_pkg::TALLY_W-1:0] tally = '0;
	bit          overflow       = 1'b0;
	logic [7:0]  motion_thr     = fdmc_pkg::THR_RESET;

	fdmc_pkg::result_t expected_tallies [$];
	int          mismatches    = 0;
	int unsigned tx_idle_pct   = 0;
	int unsigned rx_idle_pct   = 0;
	bit          long_hold_req = 1'b0;

	frame_difference_motion_counter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned chan_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic void motion_predict(input fdmc_pkg::pixel_t px, input bit last,
			output bit has_res, output fdmc_pkg::result_t res);
		fdmc_pkg::pixel_t old;
		int unsigned      gray;
		has_res = 1'b0;
		res     = '0;
		if (frame_pos < fdmc_pkg::FRAME_PIXELS) begin
			if (!awaiting_first) begin
				old  = stored_frame[fdmc_pkg::ADDR_W'(frame_pos)];
				gray = (int'(fdmc_pkg::GRAY_WB) * chan_diff(px.blue, old.blue)
					+ int'(fdmc_pkg::GRAY_WG) * chan_diff(px.green, old.green)
					+ int'(fdmc_pkg::GRAY_WR) * chan_diff(px.red, old.red)
					+ int'(fdmc_pkg::GRAY_ROUND)) >> fdmc_pkg::GRAY_SHIFT;
				if (gray > motion_thr && tally != fdmc_pkg::TALLY_MAX)
					tally++;
			end
			stored_frame[fdmc_pkg::ADDR_W'(frame_pos)] = px;
			frame_pos++;
		end else begin
			overflow = 1'b1;
		end
		if (last) begin
			if (awaiting_first) begin
				awaiting_first = 1'b0;
			end else begin
				has_res           = 1'b1;
				res.changed_count = tally;
				res.oversize      = overflow;
			end
			frame_pos = 0;
			tally     = '0;
			overflow  = 1'b0;
		end
	endfunction

	function automatic logic [7:0] nudge(input logic [7:0] ch, input int spread);
		int v;
		v = int'(ch) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	// entered and left at a falling edge
	task automatic send_pixel(input fdmc_pkg::pixel_t px, input bit last, input bit typed,
			input fdmc_pkg::result_t typed_res);
		bit                has_res;
		fdmc_pkg::result_t res;
		if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {px.red, px.green, px.blue};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		motion_predict(px, last, has_res, res);
		if (has_res)
			expected_tallies.insert(expected_tallies.size(), typed ? typed_res : res);
		@(negedge clk);
	endtask

	task automatic send_frame(input int unsigned len);
		fdmc_pkg::pixel_t px;
		int               spread;
		spread = $urandom_range(1, 80);
		for (int i = 0; i < len; i++) begin
			px = stored_frame[fdmc_pkg::ADDR_W'(i)];
			case ($urandom_range(0, 3))
				0: ;
				1: px = fdmc_pkg::pixel_t'(24'($urandom));
				default: begin
					px.red   = nudge(px.red, spread);
					px.green = nudge(px.green, spread);
					px.blue  = nudge(px.blue, spread);
				end
			endcase
			send_pixel(px, i == len - 1, 1'b0, '0);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_tallies.size() != 0)
			@(negedge clk);
		// frames without a result may still be in flight
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we     <= 1'b0;
		motion_thr = value;
	endtask

	task automatic report_mismatch(input fdmc_pkg::result_t want,
			input fdmc_pkg::result_t got, input logic [6:0] pad);
		mismatches++;
		if (mismatches <= 10)
			$display({"mismatch at %0t: expected count %0d oversize %0b, ",
				"got count %0d oversize %0b pad %0h"},
				$time, want.changed_count, want.oversize, got.changed_count,
				got.oversize, pad);
	endtask

	always @(posedge clk) begin
		fdmc_pkg::result_t got;
		fdmc_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.changed_count = m_axis_tdata[fdmc_pkg::TALLY_W-1:0];
			got.oversize      = m_axis_tuser;
			if (expected_tallies.size() == 0) begin
				report_mismatch('0, got, m_axis_tdata[23:fdmc_pkg::TALLY_W]);
			end else begin
				want = expected_tallies.pop_front();
				if (got.changed_count !== want.changed_count
						|| got.oversize !== want.oversize
						|| m_axis_tdata[23:fdmc_pkg::TALLY_W] !== '0)
					report_mismatch(want, got, m_axis_tdata[23:fdmc_pkg::TALLY_W]);
			end
		end
	end

	// result side backpressure
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		fdmc_pkg::pixel_t px;
		pixel_row_t       row;
		int unsigned      sent;
		int unsigned      len;
		int unsigned      pct_pick [4];
		pct_pick = '{0, 3, 10, 25};
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// first frame is the longest, so later frames only read written entries
		for (int i = 0; i < FILL_LEN; i++)
			send_pixel(fdmc_pkg::pixel_t'(24'($urandom)), i == FILL_LEN - 1, 1'b0, '0);

		tx_idle_pct = 10;
		rx_idle_pct = 10;
		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[5'(i)];
			send_pixel(row.px, row.last, row.typed, row.res);
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_threshold(8'd0);
				1: write_threshold(8'd255);
				2: write_threshold(fdmc_pkg::THR_RESET);
				4: write_threshold(8'd1);
				5: write_threshold(8'd254);
				default: write_threshold(8'($urandom_range(0, 255)));
			endcase
			tx_idle_pct = pct_pick[2'($urandom_range(0, 3))];
			rx_idle_pct = pct_pick[2'($urandom_range(0, 3))];
			if (p == 3) begin
				// one-word frames against a stalled receiver fill the pipeline
				tx_idle_pct   = 0;
				long_hold_req = 1'b1;
				for (int i = 0; i < 40; i++)
					send_pixel(fdmc_pkg::pixel_t'(24'($urandom)), 1'b1, 1'b0, '0);
			end
			sent = 0;
			while (sent < PHASE_WORDS) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, FILL_LEN)
					: $urandom_range(1, 24);
				send_frame(len);
				sent += len;
			end
			drain();
		end

		// no idling from here on: longest frame, every pixel far from the stored one
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_threshold(8'($urandom_range(0, 127)));
		for (int i = 0; i < FILL_LEN; i++) begin
			px.red   = {8{~stored_frame[fdmc_pkg::ADDR_W'(i)].red[7]}};
			px.green = {8{~stored_frame[fdmc_pkg::ADDR_W'(i)].green[7]}};
			px.blue  = {8{~stored_frame[fdmc_pkg::ADDR_W'(i)].blue[7]}};
			send_pixel(px, i == FILL_LEN - 1, 1'b0, '0);
		end
		for (int i = 0; i < 5; i++)
			send_frame($urandom_range(1, 24));
		drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
